FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath types of the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int ROWS         = 25;
  localparam int ROW_BYTES    = 160;
  localparam int SCREEN_BYTES = ROWS * ROW_BYTES;
  localparam int LAST_ROW     = (ROWS - 1) * ROW_BYTES;

  // Field widths
  localparam int CUR_W  = 12;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;

  // Memory index and scroll address widths
  localparam int MEM_AW  = $clog2(SCREEN_BYTES);
  localparam int SCR_RAW = $clog2(SCREEN_BYTES + 512);
  localparam int SCR_W   = (SCR_RAW > CUR_W) ? SCR_RAW : CUR_W;

  // Remainder unit: divisor holds the window length or a row length
  localparam int ROW_W     = $clog2(ROW_BYTES + 1);
  localparam int DIV_W     = (ROW_W > BYTE_W) ? ROW_W : BYTE_W;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = CUR_W / DIV_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Operations
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_HOME = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_START  = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_LINE_SKIP     = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [BYTE_W-1:0] MIN_LENGTH    = 8'd2;
  localparam logic [BYTE_W-1:0] RESET_LENGTH  = 8'd160;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_SMOD,
    S_KMOD,
    S_SRD,
    S_SWR,
    S_BLANK,
    S_CHAR,
    S_NL,
    S_BS,
    S_BSW,
    S_ATTR,
    S_WRAP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WA_CLEAR,
    WA_DST,
    WA_BLANK,
    WA_CURSOR
  } wa_sel_t;

  typedef enum logic [2:0] {
    WS_ZERO,
    WS_COPY,
    WS_SPACE,
    WS_CHAR,
    WS_ATTR
  } wd_sel_t;

  typedef enum logic {
    RD_ITEM,
    RD_SRC
  } rd_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_SCROLL,
    CUR_INC,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_WRAP
  } cur_op_t;

  typedef enum logic [2:0] {
    DV_START,
    DV_SKIP,
    DV_CURSOR,
    DV_BACK,
    DV_CUR_P1
  } div_sel_t;

  typedef struct packed {
    logic     clr_step;
    logic     latch_item;
    logic     mem_we;
    wa_sel_t  wa_sel;
    wd_sel_t  wd_sel;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cap_read;
    cur_op_t  cur_op;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_smod;
    logic     cap_kmod;
    logic     scr_init;
    logic     scr_step;
    logic     blank_init;
    logic     blank_step;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            is_newline;
    logic            is_backspace;
    logic            scroll_needed;
    logic            scr_end;
    logic            blank_end;
    logic            at_start;
    logic            div_done;
    logic            out_free;
  } stat_t;

endpackage

FILE: hdl/tcw_mod.sv
// ----------------------------------------------------------------------------
// tcw_mod
// Iterative remainder unit: restoring division, two quotient bits a cycle,
// only the remainder is kept.
// ----------------------------------------------------------------------------
module tcw_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tcw_pkg::CUR_W-1:0]  dividend,
  input  logic [tcw_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [tcw_pkg::DIV_W-1:0]  remainder
);
  import tcw_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [CUR_W-1:0]  num;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem_next;
  logic [CUR_W-1:0]  num_next;
  logic [DIV_W:0]    trial;

  always_comb begin
    rem_next = remainder;
    num_next = num;
    trial    = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {rem_next, num_next[CUR_W-1]};
      num_next = {num_next[CUR_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
      end
      rem_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      num       <= num_next;
      remainder <= rem_next;
    end
  end

endmodule

FILE: hdl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, window registers, scroll counters and the result
// register of the text console writer.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::cmd_t               cmd,
  output tcw_pkg::stat_t              st,
  input  logic [tcw_pkg::OP_W-1:0]    operation,
  input  logic [tcw_pkg::BYTE_W-1:0]  char_code,
  input  logic [tcw_pkg::BYTE_W-1:0]  attribute,
  input  logic [tcw_pkg::CUR_W-1:0]   read_address,
  input  logic                        is_last_char,
  input  logic                        cfg_we,
  input  logic [tcw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::BYTE_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::CUR_W-1:0]   cursor_offset,
  output logic [tcw_pkg::BYTE_W-1:0]  read_data,
  output logic                        text_done
);
  import tcw_pkg::*;

  logic [BYTE_W-1:0] mem [SCREEN_BYTES];
  logic [BYTE_W-1:0] mem_q;

  logic [BYTE_W-1:0] window_start;
  logic [BYTE_W-1:0] window_length;
  logic [BYTE_W-1:0] line_skip;
  logic [BYTE_W-1:0] len_eff;

  logic [CUR_W-1:0]  cursor;
  logic [CUR_W-1:0]  cursor_next;
  logic [MEM_AW-1:0] clr;

  logic [OP_W-1:0]   item_op;
  logic [BYTE_W-1:0] item_ch;
  logic [BYTE_W-1:0] item_attr;
  logic [CUR_W-1:0]  item_raddr;
  logic              item_last;
  logic              item_rd_ok;
  logic [BYTE_W-1:0] res_data;

  logic [SCR_W-1:0]  dst;
  logic [SCR_W-1:0]  src;
  logic [SCR_W-1:0]  dst_next;
  logic [SCR_W-1:0]  src_next;
  logic [BYTE_W-1:0] col;
  logic [BYTE_W-1:0] col_next;
  logic [BYTE_W-1:0] smod;
  logic [BYTE_W-1:0] kmod;
  logic [SCR_W-1:0]  blank;
  logic [SCR_W-1:0]  blank_base;
  logic [SCR_W-1:0]  scroll_limit;

  logic [CUR_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic              div_done;
  logic [DIV_W-1:0]  div_rem;

  logic [DIV_W:0]    bs_col;
  logic [DIV_W:0]    bs_lo;
  logic [DIV_W:0]    bs_hi;
  logic              bs_skip;

  logic [SCR_W-1:0]  waddr;
  logic [BYTE_W-1:0] wdata;
  logic              we_eff;
  logic [SCR_W-1:0]  raddr;
  logic              re_eff;

  assign len_eff      = (window_length < MIN_LENGTH) ? MIN_LENGTH : window_length;
  assign blank_base   = SCR_W'(LAST_ROW) + SCR_W'(window_start);
  assign scroll_limit = blank_base + SCR_W'(len_eff);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      window_length <= RESET_LENGTH;
      line_skip     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_START:  window_start  <= cfg_data;
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_LINE_SKIP:     line_skip     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Remainder unit
  always_comb begin
    div_den = DIV_W'(len_eff);
    case (cmd.div_sel)
      DV_START:  div_num = CUR_W'(window_start);
      DV_SKIP:   div_num = CUR_W'(line_skip);
      DV_CURSOR: div_num = cursor;
      DV_BACK: begin
        div_num = cursor - CUR_W'(2);
        div_den = DIV_W'(ROW_BYTES);
      end
      DV_CUR_P1: div_num = cursor + CUR_W'(1);
      default:   div_num = cursor;
    endcase
  end

  tcw_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Backspace crosses to the line above when the target column lies below
  // the window start or more than a window length past it
  assign bs_col  = (DIV_W + 1)'(div_rem);
  assign bs_lo   = (DIV_W + 1)'(window_start);
  assign bs_hi   = bs_lo + (DIV_W + 1)'(len_eff);
  assign bs_skip = (bs_col < bs_lo) || (bs_col > bs_hi);

  // Cursor
  always_comb begin
    case (cmd.cur_op)
      CUR_HOLD:    cursor_next = cursor;
      CUR_HOME:    cursor_next = CUR_W'(window_start);
      CUR_SCROLL:  cursor_next = blank_base[CUR_W-1:0];
      CUR_INC:     cursor_next = cursor + CUR_W'(1);
      CUR_NEWLINE: cursor_next = cursor + CUR_W'(len_eff) - CUR_W'(div_rem)
                                 + CUR_W'(line_skip);
      CUR_BACK:    cursor_next = cursor - (bs_skip ? CUR_W'(line_skip) : '0)
                                 - CUR_W'(2);
      CUR_WRAP:    cursor_next = (div_rem == '0) ? cursor + CUR_W'(line_skip)
                                                 : cursor;
      default:     cursor_next = cursor;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      clr    <= '0;
    end else begin
      cursor <= cursor_next;
      if (cmd.clr_step) begin
        clr <= clr + MEM_AW'(1);
      end
    end
  end

  // Item and scroll registers
  always_comb begin
    dst_next = dst + SCR_W'(1);
    src_next = src + SCR_W'(1);
    col_next = col + BYTE_W'(1);
    if (col_next == len_eff) begin
      dst_next = dst_next + SCR_W'(line_skip);
      src_next = src_next + SCR_W'(line_skip);
      col_next = kmod;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_op    <= operation;
      item_ch    <= char_code;
      item_attr  <= attribute;
      item_raddr <= read_address;
      item_last  <= is_last_char;
      item_rd_ok <= SCR_W'(read_address) < SCR_W'(SCREEN_BYTES);
      res_data   <= '0;
    end else if (cmd.cap_read) begin
      res_data   <= item_rd_ok ? mem_q : '0;
    end
    if (cmd.cap_smod) begin
      smod <= div_rem[BYTE_W-1:0];
    end
    if (cmd.cap_kmod) begin
      kmod <= div_rem[BYTE_W-1:0];
    end
    if (cmd.scr_init) begin
      dst <= SCR_W'(window_start);
      src <= SCR_W'(ROW_BYTES) + SCR_W'(window_start);
      col <= smod;
    end else if (cmd.scr_step) begin
      dst <= dst_next;
      src <= src_next;
      col <= col_next;
    end
    if (cmd.blank_init) begin
      blank <= blank_base;
    end else if (cmd.blank_step) begin
      blank <= blank + SCR_W'(2);
    end
  end

  // Screen memory: one write and one registered read per cycle
  always_comb begin
    case (cmd.wa_sel)
      WA_CLEAR:  waddr = SCR_W'(clr);
      WA_DST:    waddr = dst;
      WA_BLANK:  waddr = blank;
      WA_CURSOR: waddr = SCR_W'(cursor);
      default:   waddr = SCR_W'(cursor);
    endcase
    case (cmd.wd_sel)
      WS_ZERO:  wdata = '0;
      WS_COPY:  wdata = mem_q;
      WS_SPACE: wdata = CH_SPACE;
      WS_CHAR:  wdata = item_ch;
      WS_ATTR:  wdata = item_attr;
      default:  wdata = '0;
    endcase
    case (cmd.rd_sel)
      RD_ITEM: begin
        raddr  = SCR_W'(item_raddr);
        re_eff = cmd.rd_en && item_rd_ok;
      end
      RD_SRC: begin
        raddr  = src;
        re_eff = cmd.rd_en;
      end
      default: begin
        raddr  = src;
        re_eff = 1'b0;
      end
    endcase
  end

  // Drop stores past the end of the screen
  assign we_eff = cmd.mem_we && (waddr < SCR_W'(SCREEN_BYTES));

  always_ff @(posedge clk) begin
    if (we_eff) begin
      mem[waddr[MEM_AW-1:0]] <= wdata;
    end
    if (re_eff) begin
      mem_q <= mem[raddr[MEM_AW-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_offset <= cursor;
      read_data     <= res_data;
      text_done     <= item_last;
    end
  end

  // Status
  assign st.clr_last      = (clr == MEM_AW'(SCREEN_BYTES - 1));
  assign st.op            = item_op;
  assign st.is_newline    = (item_ch == CH_NEWLINE);
  assign st.is_backspace  = (item_ch == CH_BACKSPACE);
  assign st.scroll_needed = (SCR_W'(cursor) >= scroll_limit);
  assign st.scr_end       = (src >= SCR_W'(SCREEN_BYTES));
  assign st.blank_end     = (blank >= scroll_limit);
  assign st.at_start      = (cursor == CUR_W'(window_start));
  assign st.div_done      = div_done;
  assign st.out_free      = !out_valid || out_ready;

endmodule

FILE: hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console writer: clearing pass, item dispatch,
// scroll, character handling and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcw_pkg::stat_t st,
  output tcw_pkg::cmd_t  cmd
);
  import tcw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (st.op)
          OP_PUT:  state_next = st.scroll_needed ? S_SMOD : S_CHAR;
          OP_READ: state_next = S_READ;
          OP_HOME: state_next = S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_READ: state_next = S_DONE;
      S_SMOD: begin
        if (st.div_done) state_next = S_KMOD;
      end
      S_KMOD: begin
        if (st.div_done) state_next = S_SRD;
      end
      S_SRD:  state_next = st.scr_end ? S_BLANK : S_SWR;
      S_SWR:  state_next = S_SRD;
      S_BLANK: begin
        if (st.blank_end) state_next = S_CHAR;
      end
      S_CHAR: begin
        if (st.is_newline) begin
          state_next = S_NL;
        end else if (st.is_backspace) begin
          state_next = st.at_start ? S_DONE : S_BS;
        end else begin
          state_next = S_ATTR;
        end
      end
      S_NL: begin
        if (st.div_done) state_next = S_DONE;
      end
      S_BS: begin
        if (st.div_done) state_next = S_BSW;
      end
      S_BSW:  state_next = S_DONE;
      S_ATTR: state_next = S_WRAP;
      S_WRAP: begin
        if (st.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.mem_we   = 1'b1;
        cmd.wa_sel   = WA_CLEAR;
        cmd.wd_sel   = WS_ZERO;
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
      end
      S_DISPATCH: begin
        case (st.op)
          OP_PUT: begin
            cmd.div_start = st.scroll_needed;
            cmd.div_sel   = DV_START;
          end
          OP_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ITEM;
          end
          OP_HOME: cmd.cur_op = CUR_HOME;
          default: ;
        endcase
      end
      S_READ: cmd.cap_read = 1'b1;
      S_SMOD: begin
        if (st.div_done) begin
          cmd.cap_smod  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_SKIP;
        end
      end
      S_KMOD: begin
        if (st.div_done) begin
          cmd.cap_kmod = 1'b1;
          cmd.scr_init = 1'b1;
        end
      end
      S_SRD: begin
        if (st.scr_end) begin
          cmd.blank_init = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SRC;
        end
      end
      S_SWR: begin
        cmd.mem_we   = 1'b1;
        cmd.wa_sel   = WA_DST;
        cmd.wd_sel   = WS_COPY;
        cmd.scr_step = 1'b1;
      end
      S_BLANK: begin
        if (st.blank_end) begin
          cmd.cur_op = CUR_SCROLL;
        end else begin
          cmd.mem_we     = 1'b1;
          cmd.wa_sel     = WA_BLANK;
          cmd.wd_sel     = WS_SPACE;
          cmd.blank_step = 1'b1;
        end
      end
      S_CHAR: begin
        if (st.is_newline) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DV_CURSOR;
        end else if (st.is_backspace) begin
          cmd.div_start = !st.at_start;
          cmd.div_sel   = DV_BACK;
        end else begin
          cmd.mem_we = 1'b1;
          cmd.wa_sel = WA_CURSOR;
          cmd.wd_sel = WS_CHAR;
          cmd.cur_op = CUR_INC;
        end
      end
      S_NL: begin
        if (st.div_done) cmd.cur_op = CUR_NEWLINE;
      end
      S_BS: begin
        if (st.div_done) cmd.cur_op = CUR_BACK;
      end
      S_BSW: begin
        cmd.mem_we = 1'b1;
        cmd.wa_sel = WA_CURSOR;
        cmd.wd_sel = WS_SPACE;
      end
      S_ATTR: begin
        // remainder is taken of the cursor as it stands after this step
        cmd.mem_we    = 1'b1;
        cmd.wa_sel    = WA_CURSOR;
        cmd.wd_sel    = WS_ATTR;
        cmd.cur_op    = CUR_INC;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DV_CUR_P1;
      end
      S_WRAP: begin
        if (st.div_done) cmd.cur_op = CUR_WRAP;
      end
      S_DONE: cmd.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console writer with a character/attribute screen memory, a byte
// cursor and a clipped text window.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen memory to zero, one byte a cycle,
// and takes no word until the sweep ends; configuration writes are taken at
// any time. Items are handled one at a time, from acceptance to a loaded
// result. Newlines, backspaces away from the window start and printable
// characters use the iterative remainder unit (two bits a cycle) that forms
// the wrap and column tests. A put with the cursor past the last window line
// first scrolls: two remainder passes, then a read and a write per copied
// byte over the screen memory, then spaces written to the character bytes of
// the last window line. A result waits in an output register, and the next
// item is accepted while it waits.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::OP_W-1:0]    operation,
  input  logic [tcw_pkg::BYTE_W-1:0]  char_code,
  input  logic [tcw_pkg::BYTE_W-1:0]  attribute,
  input  logic [tcw_pkg::CUR_W-1:0]   read_address,
  input  logic                        is_last_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::CUR_W-1:0]   cursor_offset,
  output logic [tcw_pkg::BYTE_W-1:0]  read_data,
  output logic                        text_done,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::BYTE_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .operation     (operation),
    .char_code     (char_code),
    .attribute     (attribute),
    .read_address  (read_address),
    .is_last_char  (is_last_char),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_offset (cursor_offset),
    .read_data     (read_data),
    .text_done     (text_done)
  );

endmodule

FILE: sim/text_console_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. Console words (put, read,
// home) go in through a queued driver, and each response is checked against
// a screen model kept in step at every accepted word. The window registers
// are reprogrammed between phases while the block is idle: extremes first,
// then random settings. Scrolls are rationed per phase to bound run time.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS    = 1930;
  localparam int SCROLLS_PER_SET = 3;
  localparam int LONG_HOLD       = 400;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] attr;
    logic [CUR_W-1:0]  addr;
    logic              last;
  } console_cmd_t;

  typedef struct {
    logic [CUR_W-1:0]  cursor;
    logic [BYTE_W-1:0] data;
    logic              done;
  } console_resp_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation    = '0;
  logic [BYTE_W-1:0]   char_code    = '0;
  logic [BYTE_W-1:0]   attribute    = '0;
  logic [CUR_W-1:0]    read_address = '0;
  logic                is_last_char = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [CUR_W-1:0]    cursor_offset;
  logic [BYTE_W-1:0]   read_data;
  logic                text_done;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index    = '0;
  logic [BYTE_W-1:0]   cfg_data     = '0;

  // screen model state and window registers
  logic [BYTE_W-1:0] scr_mem [SCREEN_BYTES];
  logic [CUR_W-1:0]  cur       = '0;
  logic [BYTE_W-1:0] win_start = '0;
  logic [BYTE_W-1:0] win_len   = RESET_LENGTH;
  logic [BYTE_W-1:0] skip      = '0;

  console_cmd_t  queued_cmds[$];
  console_resp_t due_responses[$];

  int cmds_issued      = 0;
  int cmds_answered    = 0;
  int words_checked    = 0;
  int fail_count       = 0;
  int scroll_count     = 0;
  int scroll_allowance = SCROLLS_PER_SET;
  int settings_used    = 0;
  int stall_requests   = 0;
  int stalls_granted   = 0;
  int hold_left        = 0;
  bit tx_calm          = 1'b0;
  bit rx_calm          = 1'b0;

  text_console_writer dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic int eff_len();
    return (win_len < MIN_LENGTH) ? int'(MIN_LENGTH) : int'(win_len);
  endfunction

  function automatic void mem_write(int addr, logic [BYTE_W-1:0] v);
    if (addr < SCREEN_BYTES) scr_mem[addr] = v;
  endfunction

  function automatic logic [BYTE_W-1:0] mem_read(int addr);
    return (addr < SCREEN_BYTES) ? scr_mem[addr] : '0;
  endfunction

  function automatic bit scroll_due();
    return int'(cur) >= LAST_ROW + eff_len() + int'(win_start);
  endfunction

  function automatic void scroll_up();
    int len;
    int dst;
    int src;
    int a;
    len = eff_len();
    dst = int'(win_start);
    src = ROW_BYTES + int'(win_start);
    while (src < SCREEN_BYTES) begin
      mem_write(dst, mem_read(src));
      dst++;
      src++;
      if (dst % len == 0) begin
        dst += int'(skip);
        src += int'(skip);
      end
    end
    // blank only the character bytes of the last line
    for (a = LAST_ROW + int'(win_start); a < LAST_ROW + len + int'(win_start); a += 2)
      mem_write(a, CH_SPACE);
    cur = 12'(LAST_ROW + int'(win_start));
    scroll_count++;
  endfunction

  function automatic void put_char(logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] attr);
    int len;
    int col;
    int nxt;
    logic [CUR_W-1:0] back;
    len = eff_len();
    if (scroll_due()) scroll_up();
    if (ch == CH_NEWLINE) begin
      nxt = int'(cur) + (len - int'(cur) % len) + int'(skip);
      cur = 12'(nxt);
    end else if (ch == CH_BACKSPACE) begin
      if (int'(cur) == int'(win_start)) return;
      back = cur - 12'd2;
      col = int'(back) % ROW_BYTES;
      if (col < int'(win_start) || col > int'(win_start) + len) cur = cur - {4'd0, skip};
      cur = cur - 12'd2;
      mem_write(int'(cur), CH_SPACE);
    end else begin
      mem_write(int'(cur), ch);
      cur = cur + 12'd1;
      mem_write(int'(cur), attr);
      cur = cur + 12'd1;
      if (int'(cur) % len == 0) cur = cur + {4'd0, skip};
    end
  endfunction

  function automatic console_resp_t apply_console_cmd(console_cmd_t c);
    console_resp_t r;
    r.data = '0;
    case (c.op)
      OP_PUT:  put_char(c.ch, c.attr);
      OP_READ: r.data = mem_read(int'(c.addr));
      OP_HOME: cur = {4'd0, win_start};
      default: ;
    endcase
    r.cursor = cur;
    r.done   = c.last;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_words
    console_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        due_responses.push_back(apply_console_cmd('{operation, char_code, attribute,
                                                     read_address, is_last_char}));
      if (!in_valid || in_ready) begin
        if (queued_cmds.size() == 0 || (!tx_calm && $urandom_range(0, 99) < 14)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = queued_cmds.pop_front();
          // ration scrolls: send the cursor home once this setting used its share
          if (nxt.op == OP_PUT && scroll_due() && scroll_count >= scroll_allowance)
            nxt.op = OP_HOME;
          operation    <= nxt.op;
          char_code    <= nxt.ch;
          attribute    <= nxt.attr;
          read_address <= nxt.addr;
          is_last_char <= nxt.last;
          in_valid     <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_results
    console_resp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        cmds_answered++;
        if (due_responses.size() == 0) begin
          $display("%0t: unexpected result, cursor_offset %0d read_data %0d text_done %0b",
                   $time, cursor_offset, read_data, text_done);
          fail_count++;
        end else begin
          want = due_responses.pop_front();
          words_checked++;
          if (cursor_offset !== want.cursor) begin
            $display("%0t: cursor_offset mismatch, expected %0d, actual %0d",
                     $time, want.cursor, cursor_offset);
            fail_count++;
          end
          if (read_data !== want.data) begin
            $display("%0t: read_data mismatch, expected %0d, actual %0d",
                     $time, want.data, read_data);
            fail_count++;
          end
          if (text_done !== want.done) begin
            $display("%0t: text_done mismatch, expected %0b, actual %0b",
                     $time, want.done, text_done);
            fail_count++;
          end
        end
      end
      if (stalls_granted != stall_requests) begin
        stalls_granted++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_calm || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] attr,
                      logic [CUR_W-1:0] addr, logic last);
    queued_cmds.push_back('{op, ch, attr, addr, last});
    cmds_issued++;
  endtask

  task automatic wait_answered();
    while (cmds_answered < cmds_issued) @(posedge clk);
  endtask

  task automatic wait_cfg_taken();
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write all three window registers, valid held high across the words
  task automatic program_window(logic [BYTE_W-1:0] ws, logic [BYTE_W-1:0] wl,
                                logic [BYTE_W-1:0] ls);
    cfg_index <= REG_WINDOW_START;
    cfg_data  <= ws;
    cfg_valid <= 1'b1;
    wait_cfg_taken();
    win_start = ws;
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data  <= wl;
    wait_cfg_taken();
    win_len = wl;
    cfg_index <= REG_LINE_SKIP;
    cfg_data  <= ls;
    wait_cfg_taken();
    skip = ls;
    cfg_valid <= 1'b0;
    settings_used++;
    scroll_allowance = scroll_count + SCROLLS_PER_SET;
  endtask

  task automatic send_random_cmd();
    int pick;
    logic [OP_W-1:0] op;
    logic [BYTE_W-1:0] ch;
    logic [CUR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 78) op = OP_PUT;
    else if (pick < 94) op = OP_READ;
    else if (pick < 97) op = OP_HOME;
    else op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 10) ch = CH_NEWLINE;
    else if (pick < 17) ch = CH_BACKSPACE;
    else if (pick < 25) ch = 8'($urandom_range(0, 255));
    else ch = 8'($urandom_range(32, 126));
    if ($urandom_range(0, 9) == 0) addr = 12'($urandom_range(SCREEN_BYTES, 4095));
    else addr = 12'($urandom_range(0, SCREEN_BYTES - 1));
    send(op, ch, 8'($urandom_range(0, 255)), addr, $urandom_range(0, 4) == 0);
  endtask

  initial begin : stimulus
    int phase;
    int count;
    int total;
    int i;
    foreach (scr_mem[j]) scr_mem[j] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset window: cleared memory, out-of-range read, unused op, backspace at start
    send(OP_READ, 8'h00, 8'h00, 12'd0, 1'b0);
    send(OP_READ, 8'hFF, 8'hFF, 12'hFFF, 1'b0);
    send(OP_UNUSED, 8'hFF, 8'hFF, 12'hFFF, 1'b1);
    send(OP_PUT, CH_BACKSPACE, 8'h55, 12'd0, 1'b0);
    send(OP_PUT, 8'hFF, 8'hFF, 12'd0, 1'b0);
    send(OP_PUT, 8'h00, 8'h00, 12'hFFF, 1'b1);
    send(OP_PUT, CH_NEWLINE, 8'hAA, 12'd0, 1'b0);
    send(OP_PUT, CH_BACKSPACE, 8'h00, 12'd0, 1'b0);
    send(OP_READ, 8'h00, 8'h00, 12'd158, 1'b0);
    send(OP_READ, 8'h00, 8'h00, 12'd1, 1'b0);
    send(OP_HOME, 8'h00, 8'h00, 12'd0, 1'b1);
    wait_answered();

    // cursor 0 off the window start: backspace wraps below zero, next put scrolls
    program_window(8'd6, 8'd8, 8'd0);
    send(OP_PUT, CH_BACKSPACE, 8'h00, 12'd0, 1'b0);
    send(OP_PUT, 8'h78, 8'h1E, 12'd0, 1'b0);
    send(OP_READ, 8'h00, 8'h00, 12'd3846, 1'b0);
    send(OP_READ, 8'h00, 8'h00, 12'd3848, 1'b0);
    send(OP_READ, 8'h00, 8'h00, 12'd3849, 1'b0);
    send(OP_PUT, CH_NEWLINE, 8'h00, 12'd0, 1'b1);
    send(OP_HOME, 8'h00, 8'h00, 12'd0, 1'b0);
    wait_answered();

    // window length below the minimum
    program_window(8'd0, 8'd0, 8'd3);
    send(OP_PUT, 8'h61, 8'h07, 12'd0, 1'b0);
    send(OP_PUT, 8'h62, 8'hF0, 12'd0, 1'b0);
    send(OP_PUT, CH_NEWLINE, 8'h00, 12'd0, 1'b0);
    send(OP_PUT, CH_BACKSPACE, 8'h00, 12'd0, 1'b1);
    send(OP_READ, 8'h00, 8'h00, 12'd2, 1'b0);

    total = 0;
    for (phase = 0; total < RANDOM_WORDS; phase++) begin
      wait_answered();
      case (phase)
        0: program_window(8'd159, 8'd160, 8'd158);
        1: program_window(8'd0, 8'd2, 8'd158);
        2: program_window(8'd159, 8'd2, 8'd0);
        3: program_window(8'd0, 8'd160, 8'd0);
        4: program_window(8'd0, 8'd1, 8'd158);
        default: program_window(8'($urandom_range(0, 159)),
                                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1))
                                                            : 8'($urandom_range(2, 160)),
                                8'($urandom_range(0, 158)));
      endcase
      tx_calm = (phase == 3 || phase == 11);
      rx_calm = tx_calm;
      count = $urandom_range(80, 120);
      for (i = 0; i < count; i++) begin
        // hold the sender until the block has answered everything
        if (phase == 6 && i == count / 2) wait_answered();
        send_random_cmd();
      end
      total += count;
      if (phase == 2 || phase == 8) stall_requests++;
    end

    wait_answered();
    repeat (20) @(posedge clk);
    if (due_responses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_responses.size());
      fail_count++;
    end
    $display("Checked %0d console words over %0d window settings, %0d scrolls,",
             words_checked, settings_used, scroll_count);
    $display("with random idling on both sides and %0d long output stalls.", stalls_granted);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("%0t: timeout, %0d of %0d words answered", $time, cmds_answered, cmds_issued);
    $display("Regression FAIL");
    $finish;
  end

endmodule
